[rtl/sbpq_pkg.sv]
package sbpq_pkg;

  localparam int unsigned BUF_DEPTH = 1024;
  localparam int unsigned IW = $clog2(BUF_DEPTH);
  localparam int unsigned SW = $clog2(BUF_DEPTH + 1);
  localparam int unsigned AW = $clog2(3 * BUF_DEPTH);
  localparam int unsigned WORD_W = 40;

  typedef logic [IW-1:0] idx_t;
  typedef logic [SW-1:0] size_t;
  typedef logic [AW-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam logic [SW:0] DEPTH_W = (SW + 1)'(BUF_DEPTH);
  localparam idx_t LAST_IDX = IW'(BUF_DEPTH - 1);

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP = 1'b1;

  localparam logic [1:0] ROLE_TOP = 2'd0;
  localparam logic [1:0] ROLE_MID = 2'd1;
  localparam logic [1:0] ROLE_BOT = 2'd2;
  localparam logic [5:0] ROLES_RESET = 6'b10_01_00;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic decode;
    logic chk_step;
    logic set_ovf;
    logic sl_setup;
    logic cp_rd;
    logic cp_wr;
    logic sl_end;
    logic push_wr;
    logic pop_rd;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic chk_done;
    logic step_bad;
    logic fit;
    logic sl_zero;
    logic sl_last;
    logic cp_zero;
    logic out_free;
    logic [5:0] roles;
    logic [2:0][SW-1:0] sizes;
  } sts_t;

  // Reduces a value below twice the depth into the ring range.
  function automatic idx_t wrap(logic [SW:0] x);
    logic [SW:0] r;
    r = (x >= DEPTH_W) ? (x - DEPTH_W) : x;
    return r[IW-1:0];
  endfunction

  function automatic idx_t inc(idx_t x);
    return (x == LAST_IDX) ? '0 : (x + 1'b1);
  endfunction

  function automatic addr_t phys_addr(logic [1:0] phys, idx_t idx);
    addr_t a;
    case (phys)
      2'd0: a = AW'(idx);
      2'd1: a = AW'(BUF_DEPTH) + AW'(idx);
      default: a = AW'(2 * BUF_DEPTH) + AW'(idx);
    endcase
    return a;
  endfunction

  function automatic logic [1:0] role_field(logic [5:0] roles, logic [1:0] role);
    logic [1:0] f;
    case (role)
      ROLE_TOP: f = roles[1:0];
      ROLE_MID: f = roles[3:2];
      default: f = roles[5:4];
    endcase
    return f;
  endfunction

endpackage

[rtl/sbpq_if.sv]
interface sbpq_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [7:0] item_pri;
  logic [31:0] item_loc;
  modport source(output valid, kind, item_pri, item_loc, input ready);
  modport sink(input valid, kind, item_pri, item_loc, output ready);
endinterface

interface sbpq_out_if;
  logic valid;
  logic ready;
  logic found;
  logic [7:0] out_pri;
  logic [31:0] out_loc;
  logic now_empty;
  logic overflowed;
  modport source(output valid, found, out_pri, out_loc, now_empty, overflowed, input ready);
  modport sink(input valid, found, out_pri, out_loc, now_empty, overflowed, output ready);
endinterface

[rtl/sbpq_ram.sv]
module sbpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sbpq_ctrl.sv]
module sbpq_ctrl import sbpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CHECK, S_SL_SETUP, S_CP_RD, S_CP_WR, S_SL_END,
    S_APPEND, S_POP, S_RES
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d = sts_i.is_pop ? S_POP : S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.chk_done) begin
          if (sts_i.step_bad) begin
            cmd_o.set_ovf = 1'b1;
            state_d = S_RES;
          end else begin
            cmd_o.chk_step = 1'b1;
          end
        end else if (sts_i.fit) begin
          state_d = sts_i.sl_zero ? S_APPEND : S_SL_SETUP;
        end else begin
          cmd_o.set_ovf = 1'b1;
          state_d = S_RES;
        end
      end
      S_SL_SETUP: begin
        cmd_o.sl_setup = 1'b1;
        state_d = S_CP_RD;
      end
      S_CP_RD: begin
        if (sts_i.cp_zero) begin
          state_d = S_SL_END;
        end else begin
          cmd_o.cp_rd = 1'b1;
          state_d = S_CP_WR;
        end
      end
      S_CP_WR: begin
        cmd_o.cp_wr = 1'b1;
        state_d = S_CP_RD;
      end
      S_SL_END: begin
        cmd_o.sl_end = 1'b1;
        state_d = sts_i.sl_last ? S_APPEND : S_SL_SETUP;
      end
      S_APPEND: begin
        cmd_o.push_wr = 1'b1;
        state_d = S_RES;
      end
      S_POP: begin
        cmd_o.pop_rd = 1'b1;
        state_d = S_RES;
      end
      S_RES: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/sbpq_dp.sv]
module sbpq_dp import sbpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        kind_i,
  input  logic [7:0]  pri_i,
  input  logic [31:0] loc_i,
  input  logic        out_ready_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  output logic        found_o,
  output logic [7:0]  out_pri_o,
  output logic [31:0] out_loc_o,
  output logic        now_empty_o,
  output logic        overflowed_o
);

  logic        kind_q;
  logic [7:0]  pri_q;
  logic [31:0] loc_q;
  idx_t        heads_q [3];
  size_t       sizes_q [3];
  logic [5:0]  roles_q;
  logic [5:0]  wtp_q;
  logic        wset_q;
  logic [1:0]  tgt_q;
  logic [5:0]  sr_q;
  size_t       ss_q [3];
  logic [5:0]  chk_cnt_q;
  logic [5:0]  sl_cnt_q;
  size_t       n_q;
  size_t       n_rem_q;
  logic        prep_q;
  idx_t        src_q;
  idx_t        dst_q;
  idx_t        nh_q;
  logic [1:0]  sphys_q;
  logic [1:0]  dphys_q;
  logic        ovf_q;
  logic        found_q;
  logic        out_valid_q;
  logic        out_found_q;
  logic [7:0]  out_pri_q;
  logic [31:0] out_loc_q;
  logic        out_empty_q;
  logic        out_ovf_q;

  logic        ram_we;
  addr_t       ram_waddr;
  word_t       ram_wdata;
  logic        ram_re;
  addr_t       ram_raddr;
  word_t       ram_rdata;

  logic [5:0]  p;
  logic [1:0]  rt, rm, rb;
  logic [1:0]  st, sm, sb;
  logic [SW:0] ss_sum;
  logic [1:0]  push_phys;
  idx_t        push_idx;
  idx_t        mid_tail;
  logic        all_empty;

  assign p = pri_q[5:0];
  assign rt = roles_q[1:0];
  assign rm = roles_q[3:2];
  assign rb = roles_q[5:4];
  assign st = sr_q[1:0];
  assign sm = sr_q[3:2];
  assign sb = sr_q[5:4];
  assign ss_sum = {1'b0, ss_q[sb]} + {1'b0, ss_q[sm]};
  assign push_phys = role_field(roles_q, tgt_q);
  assign push_idx = wrap({1'b0, SW'(heads_q[push_phys])} + {1'b0, sizes_q[push_phys]});
  assign mid_tail = wrap({1'b0, SW'(heads_q[rm])} + {1'b0, sizes_q[rm]} - 1'b1);
  assign all_empty = (sizes_q[0] == '0) && (sizes_q[1] == '0) && (sizes_q[2] == '0);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = phys_addr(dphys_q, dst_q);
    ram_wdata = ram_rdata;
    ram_re = 1'b0;
    ram_raddr = phys_addr(sphys_q, src_q);
    if (cmd_i.cp_rd) begin
      ram_re = 1'b1;
    end
    if (cmd_i.cp_wr) begin
      ram_we = 1'b1;
    end
    if (cmd_i.push_wr) begin
      ram_we = 1'b1;
      ram_waddr = phys_addr(push_phys, push_idx);
      ram_wdata = {pri_q, loc_q};
    end
    if (cmd_i.pop_rd) begin
      ram_re = 1'b1;
      if (sizes_q[rb] != '0) begin
        ram_raddr = phys_addr(rb, heads_q[rb]);
      end else if (sizes_q[rm] != '0) begin
        ram_raddr = phys_addr(rm, mid_tail);
      end else begin
        ram_raddr = phys_addr(rt, heads_q[rt]);
      end
    end
  end

  sbpq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(3 * BUF_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Input word and the window state.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      pri_q <= pri_i;
      loc_q <= loc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        heads_q[i] <= '0;
        sizes_q[i] <= '0;
        ss_q[i] <= '0;
      end
      roles_q <= ROLES_RESET;
      wtp_q <= '0;
      wset_q <= 1'b0;
      tgt_q <= ROLE_TOP;
      sr_q <= ROLES_RESET;
      chk_cnt_q <= '0;
      sl_cnt_q <= '0;
      n_q <= '0;
      n_rem_q <= '0;
      prep_q <= 1'b0;
      src_q <= '0;
      dst_q <= '0;
      nh_q <= '0;
      sphys_q <= '0;
      dphys_q <= '0;
      ovf_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.decode) begin
        ovf_q <= 1'b0;
        found_q <= 1'b0;
        sr_q <= roles_q;
        for (int i = 0; i < 3; i++) begin
          ss_q[i] <= sizes_q[i];
        end
        if (!wset_q) begin
          tgt_q <= ROLE_TOP;
          chk_cnt_q <= '0;
          sl_cnt_q <= '0;
        end else if (p < wtp_q) begin
          tgt_q <= ((p + 1'b1) == wtp_q) ? ROLE_MID : ROLE_BOT;
          chk_cnt_q <= '0;
          sl_cnt_q <= '0;
        end else begin
          tgt_q <= ROLE_TOP;
          chk_cnt_q <= p - wtp_q;
          sl_cnt_q <= p - wtp_q;
        end
      end
      if (cmd_i.chk_step) begin
        chk_cnt_q <= chk_cnt_q - 1'b1;
        if (ss_q[sb] <= ss_q[sm]) begin
          ss_q[sm] <= ss_sum[SW-1:0];
          ss_q[sb] <= '0;
          sr_q <= {sm, st, sb};
        end else begin
          ss_q[sb] <= ss_sum[SW-1:0];
          ss_q[sm] <= '0;
          sr_q <= {sb, st, sm};
        end
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.sl_setup) begin
        if (sizes_q[rb] <= sizes_q[rm]) begin
          prep_q <= 1'b1;
          n_q <= sizes_q[rb];
          n_rem_q <= sizes_q[rb];
          sphys_q <= rb;
          src_q <= heads_q[rb];
          dphys_q <= rm;
          dst_q <= wrap({1'b0, SW'(heads_q[rm])} + DEPTH_W - {1'b0, sizes_q[rb]});
          nh_q <= wrap({1'b0, SW'(heads_q[rm])} + DEPTH_W - {1'b0, sizes_q[rb]});
        end else begin
          prep_q <= 1'b0;
          n_q <= sizes_q[rm];
          n_rem_q <= sizes_q[rm];
          sphys_q <= rm;
          src_q <= heads_q[rm];
          dphys_q <= rb;
          dst_q <= wrap({1'b0, SW'(heads_q[rb])} + {1'b0, sizes_q[rb]});
        end
      end
      if (cmd_i.cp_wr) begin
        src_q <= inc(src_q);
        dst_q <= inc(dst_q);
        n_rem_q <= n_rem_q - 1'b1;
      end
      if (cmd_i.sl_end) begin
        sl_cnt_q <= sl_cnt_q - 1'b1;
        wtp_q <= wtp_q + 1'b1;
        if (prep_q) begin
          roles_q <= {rm, rt, rb};
          if (n_q != '0) begin
            heads_q[rm] <= nh_q;
            sizes_q[rm] <= sizes_q[rm] + n_q;
            heads_q[rb] <= '0;
            sizes_q[rb] <= '0;
          end
        end else begin
          roles_q <= {rb, rt, rm};
          if (n_q != '0) begin
            sizes_q[rb] <= sizes_q[rb] + n_q;
            heads_q[rm] <= '0;
            sizes_q[rm] <= '0;
          end
        end
      end
      if (cmd_i.push_wr) begin
        sizes_q[push_phys] <= sizes_q[push_phys] + 1'b1;
        if (!wset_q) begin
          wtp_q <= p;
          wset_q <= 1'b1;
        end
      end
      if (cmd_i.pop_rd) begin
        if (sizes_q[rb] != '0) begin
          heads_q[rb] <= inc(heads_q[rb]);
          sizes_q[rb] <= sizes_q[rb] - 1'b1;
          found_q <= 1'b1;
        end else if (sizes_q[rm] != '0) begin
          sizes_q[rm] <= sizes_q[rm] - 1'b1;
          found_q <= 1'b1;
        end else if (sizes_q[rt] != '0) begin
          heads_q[rt] <= inc(heads_q[rt]);
          sizes_q[rt] <= sizes_q[rt] - 1'b1;
          found_q <= 1'b1;
        end
      end
    end
  end

  // Result register: holds one finished word while the next one is worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_found_q <= found_q;
      out_pri_q <= found_q ? ram_rdata[39:32] : 8'd0;
      out_loc_q <= found_q ? ram_rdata[31:0] : 32'd0;
      out_empty_q <= all_empty;
      out_ovf_q <= ovf_q;
    end
  end

  always_comb begin
    sts_o.is_pop = (kind_q == KIND_POP);
    sts_o.chk_done = (chk_cnt_q == '0);
    sts_o.step_bad = (ss_sum > DEPTH_W);
    sts_o.fit = (ss_q[role_field(sr_q, tgt_q)] < SW'(BUF_DEPTH));
    sts_o.sl_zero = (sl_cnt_q == '0);
    sts_o.sl_last = (sl_cnt_q == 6'd1);
    sts_o.cp_zero = (n_rem_q == '0);
    sts_o.out_free = !out_valid_q || out_ready_i;
    sts_o.roles = roles_q;
    sts_o.sizes = {sizes_q[2], sizes_q[1], sizes_q[0]};
  end

  assign out_valid_o = out_valid_q;
  assign found_o = out_found_q;
  assign out_pri_o = out_pri_q;
  assign out_loc_o = out_loc_q;
  assign now_empty_o = out_empty_q;
  assign overflowed_o = out_ovf_q;

endmodule

[rtl/sliding_three_bucket_priority_queue.sv]
// Priority queue over three ring buckets in one shared RAM, one word in and one
// result word out per request. A pop passes through capture, decode, RAM read
// and result; the result waits while the output register is still full. A push
// that needs no window slide passes through capture, decode, size check, RAM
// write and result. A push that raises the window by d levels first runs d size
// checks, then d slides; each slide has a setup step, one read and one write for
// every item moved on the single RAM port pair, and an end step. A dropped push
// returns after the failing check. The next word is taken while a finished
// result still waits in the output register.
module sliding_three_bucket_priority_queue import sbpq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  sbpq_in_if.sink    in_i,
  sbpq_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each request; it never touches the data itself.
  sbpq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // The datapath holds bucket pointers, the window, the RAM and the result.
  sbpq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .kind_i      (in_i.kind),
    .pri_i       (in_i.item_pri),
    .loc_i       (in_i.item_loc),
    .out_ready_i (out_o.ready),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .found_o     (out_o.found),
    .out_pri_o   (out_o.out_pri),
    .out_loc_o   (out_o.out_loc),
    .now_empty_o (out_o.now_empty),
    .overflowed_o(out_o.overflowed)
  );

  assign in_i.ready = cmd.in_ready;

`ifndef SYNTHESIS
  // No bucket ever grows past its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.sizes[0] <= SW'(BUF_DEPTH)) && (sts.sizes[1] <= SW'(BUF_DEPTH)) &&
    (sts.sizes[2] <= SW'(BUF_DEPTH)))
    else $error("bucket size beyond depth");

  // The roles always name three distinct physical buckets.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.roles[1:0] != 2'd3) && (sts.roles[3:2] != 2'd3) && (sts.roles[5:4] != 2'd3) &&
    (sts.roles[1:0] != sts.roles[3:2]) && (sts.roles[1:0] != sts.roles[5:4]) &&
    (sts.roles[3:2] != sts.roles[5:4]))
    else $error("role map is not a permutation");

  // A popped item never comes with a dropped-push flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.found |-> !out_o.overflowed)
    else $error("found and overflowed together");

  // One request at a time: no word is taken in the cycle after one was.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while busy");
`endif

endmodule
